// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KLEX_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("lexer assertion failed");

// Check that a condition in the next cycle follows from a trigger.
`define KLEX_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("lexer assertion failed");

`endif

// ===== hdl/klex_pkg.sv =====
// Types, token codes, character codes and keyword table for the lexer.
package klex_pkg;

    localparam int MAX_NAME_CHARS_DEF = 8;
    localparam int NUMBER_WIDTH_DEF   = 32;
    localparam int TEXT_CHARS         = 8;
    localparam int QUEUE_DEPTH        = 8;
    localparam int KEYWORD_COUNT      = 15;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_NAME,
        MODE_LT,
        MODE_GT,
        MODE_COLON
    } mode_t;

    localparam logic [4:0] K_INT       = 5'd0;
    localparam logic [4:0] K_NAME      = 5'd1;
    localparam logic [4:0] K_FIRST_KEY = 5'd2;
    localparam logic [4:0] K_ADD       = 5'd17;
    localparam logic [4:0] K_SUB       = 5'd18;
    localparam logic [4:0] K_MUL       = 5'd19;
    localparam logic [4:0] K_DIV       = 5'd20;
    localparam logic [4:0] K_EQ        = 5'd21;
    localparam logic [4:0] K_OPEN      = 5'd22;
    localparam logic [4:0] K_CLOSE     = 5'd23;
    localparam logic [4:0] K_LT        = 5'd24;
    localparam logic [4:0] K_LE        = 5'd25;
    localparam logic [4:0] K_NE        = 5'd26;
    localparam logic [4:0] K_GT        = 5'd27;
    localparam logic [4:0] K_GE        = 5'd28;
    localparam logic [4:0] K_ASS       = 5'd29;
    localparam logic [4:0] K_EOL       = 5'd30;
    localparam logic [4:0] K_ERR       = 5'd31;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // Keyword spellings, first character in the low byte.
    localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
        64'h0000_006E_6967_6562,  // begin
        64'h0000_0000_0064_6E65,  // end
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6E65_6874,  // then
        64'h0000_0000_6573_6C65,  // else
        64'h0000_0065_6C69_6877,  // while
        64'h0000_0000_0000_6F64,  // do
        64'h0000_0000_0074_6F6E,  // not
        64'h0000_0000_0064_6E61,  // and
        64'h0000_0000_0000_726F,  // or
        64'h0000_0000_6575_7274,  // true
        64'h0000_0065_736C_6166,  // false
        64'h0000_0000_0072_6F66,  // for
        64'h0000_006C_6974_6E75,  // until
        64'h0000_0000_7065_7473   // step
    };
    localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd3,
        4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd4
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] text;
        logic [3:0]  len;
        logic [31:0] num;
        logic [15:0] line;
        logic [7:0]  index;
        logic        trunc;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     slot_a;
        token_t     slot_b;
    } push_t;

    function automatic logic char_is_numeral(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic char_is_alpha(input logic [7:0] c);
        return c inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};
    endfunction

    function automatic logic [4:0] keyword_kind(input logic [63:0] text,
                                                input logic [3:0] len);
        logic [4:0] kind;
        kind = K_NAME;
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (text == KW_TEXT[i] && len == KW_LEN[i]) begin
                kind = K_FIRST_KEY + 5'(i);
            end
        end
        return kind;
    endfunction

    function automatic token_t make_token(input logic [4:0] kind,
                                          input logic [63:0] text,
                                          input logic [3:0] len);
        token_t t;
        t = '0;
        t.kind = kind;
        t.text = text;
        t.len  = len;
        return t;
    endfunction

endpackage

// ===== hdl/klex_scan.sv =====
// Scan state and per-character token decision of the lexer.
`include "assert_macros.svh"

module klex_scan #(
    parameter int MAX_NAME_CHARS = klex_pkg::MAX_NAME_CHARS_DEF,
    parameter int NUMBER_WIDTH   = klex_pkg::NUMBER_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [7:0]       in_char,
    output klex_pkg::push_t  push
);

    localparam int NW = NUMBER_WIDTH;

    klex_pkg::mode_t  mode_reg, mode_next;
    logic [63:0]      buf_reg, buf_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [NW-1:0]    acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [15:0]      line_reg, line_next;
    logic [7:0]       idx_reg, idx_next;

    logic [NW+3:0]    prod;
    logic [NW+31:0]   acc_ext;
    logic             over32;
    logic [63:0]      char_word;
    logic [5:0]       shamt;
    logic             done;
    logic             held_v, new_v, is_eol;
    klex_pkg::token_t held_tok, new_tok, tok_a, tok_b;
    logic [7:0]       idx_plus1, idx_plus2;
    logic             held_num_or_name;
    logic             eol_in_idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= klex_pkg::MODE_IDLE;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            line_reg <= '0;
            idx_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
            line_reg <= line_next;
            idx_reg  <= idx_next;
        end
    end

    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + (NW+4)'(in_char - klex_pkg::CH_ZERO);
    assign acc_ext   = {32'b0, acc_reg};
    assign over32    = |acc_ext[NW+31:32];
    assign char_word = {56'b0, in_char};
    assign shamt     = {cnt_reg[2:0], 3'b000};
    assign idx_plus1 = (idx_reg == 8'hFF) ? 8'hFF : idx_reg + 8'd1;
    assign idx_plus2 = (idx_plus1 == 8'hFF) ? 8'hFF : idx_plus1 + 8'd1;

    always_comb begin
        mode_next = mode_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        line_next = line_reg;
        idx_next  = idx_reg;
        done      = 1'b0;
        held_v    = 1'b0;
        new_v     = 1'b0;
        is_eol    = 1'b0;
        held_tok  = '0;
        new_tok   = '0;

        if (in_valid) begin
            case (mode_reg)
                klex_pkg::MODE_NUM: begin
                    if (klex_pkg::char_is_numeral(in_char)) begin
                        done = 1'b1;
                        if (|prod[NW+3:NW]) begin
                            acc_next = '1;
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = prod[NW-1:0];
                        end
                        if (cnt_reg < 4'(klex_pkg::TEXT_CHARS)) begin
                            buf_next = buf_reg | (char_word << shamt);
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                end
                klex_pkg::MODE_NAME: begin
                    if (klex_pkg::char_is_alpha(in_char)
                            || klex_pkg::char_is_numeral(in_char)) begin
                        done = 1'b1;
                        if (cnt_reg < 4'(MAX_NAME_CHARS)) begin
                            buf_next = buf_reg | (char_word << shamt);
                            cnt_next = cnt_reg + 4'd1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                klex_pkg::MODE_LT: begin
                    if (in_char == klex_pkg::CH_EQ || in_char == klex_pkg::CH_GT) begin
                        done    = 1'b1;
                        new_v   = 1'b1;
                        new_tok = klex_pkg::make_token(
                            (in_char == klex_pkg::CH_EQ) ? klex_pkg::K_LE : klex_pkg::K_NE,
                            {48'b0, in_char, klex_pkg::CH_LT}, 4'd2);
                    end
                end
                klex_pkg::MODE_GT: begin
                    if (in_char == klex_pkg::CH_EQ) begin
                        done    = 1'b1;
                        new_v   = 1'b1;
                        new_tok = klex_pkg::make_token(klex_pkg::K_GE,
                            {48'b0, klex_pkg::CH_EQ, klex_pkg::CH_GT}, 4'd2);
                    end
                end
                klex_pkg::MODE_COLON: begin
                    if (in_char == klex_pkg::CH_EQ) begin
                        done    = 1'b1;
                        new_v   = 1'b1;
                        new_tok = klex_pkg::make_token(klex_pkg::K_ASS,
                            {48'b0, klex_pkg::CH_EQ, klex_pkg::CH_COLON}, 4'd2);
                    end
                end
                default: ;
            endcase

            if (done) begin
                if (new_v) begin
                    mode_next = klex_pkg::MODE_IDLE;
                end
            end else begin
                // Flush the held token.
                case (mode_reg)
                    klex_pkg::MODE_NUM: begin
                        held_v   = 1'b1;
                        held_tok = klex_pkg::make_token(klex_pkg::K_INT, buf_reg, cnt_reg);
                        held_tok.num   = over32 ? 32'hFFFF_FFFF : acc_ext[31:0];
                        held_tok.trunc = ovf_reg | over32;
                    end
                    klex_pkg::MODE_NAME: begin
                        held_v   = 1'b1;
                        held_tok = klex_pkg::make_token(
                            ovf_reg ? klex_pkg::K_NAME : klex_pkg::keyword_kind(buf_reg, cnt_reg),
                            buf_reg, cnt_reg);
                        held_tok.trunc = ovf_reg;
                    end
                    klex_pkg::MODE_LT: begin
                        held_v   = 1'b1;
                        held_tok = klex_pkg::make_token(klex_pkg::K_LT,
                            {56'b0, klex_pkg::CH_LT}, 4'd1);
                    end
                    klex_pkg::MODE_GT: begin
                        held_v   = 1'b1;
                        held_tok = klex_pkg::make_token(klex_pkg::K_GT,
                            {56'b0, klex_pkg::CH_GT}, 4'd1);
                    end
                    klex_pkg::MODE_COLON: begin
                        held_v   = 1'b1;
                        held_tok = klex_pkg::make_token(klex_pkg::K_ERR,
                            {56'b0, klex_pkg::CH_COLON}, 4'd1);
                    end
                    default: ;
                endcase
                mode_next = klex_pkg::MODE_IDLE;
                buf_next  = '0;
                cnt_next  = '0;
                acc_next  = '0;
                ovf_next  = 1'b0;

                // Scan the character from idle.
                if (in_char inside {klex_pkg::CH_SPACE, klex_pkg::CH_TAB, klex_pkg::CH_NL}) begin
                    mode_next = klex_pkg::MODE_IDLE;
                end else if (klex_pkg::char_is_numeral(in_char)) begin
                    mode_next = klex_pkg::MODE_NUM;
                    acc_next  = NW'(in_char - klex_pkg::CH_ZERO);
                    buf_next  = char_word;
                    cnt_next  = 4'd1;
                end else if (klex_pkg::char_is_alpha(in_char)) begin
                    mode_next = klex_pkg::MODE_NAME;
                    buf_next  = char_word;
                    cnt_next  = 4'd1;
                end else begin
                    case (in_char)
                        klex_pkg::CH_LT:    mode_next = klex_pkg::MODE_LT;
                        klex_pkg::CH_GT:    mode_next = klex_pkg::MODE_GT;
                        klex_pkg::CH_COLON: mode_next = klex_pkg::MODE_COLON;
                        klex_pkg::CH_NUL: begin
                            new_v   = 1'b1;
                            is_eol  = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_EOL, '0, 4'd0);
                        end
                        klex_pkg::CH_ADD: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_ADD, char_word, 4'd1);
                        end
                        klex_pkg::CH_SUB: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_SUB, char_word, 4'd1);
                        end
                        klex_pkg::CH_MUL: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_MUL, char_word, 4'd1);
                        end
                        klex_pkg::CH_DIV: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_DIV, char_word, 4'd1);
                        end
                        klex_pkg::CH_EQ: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_EQ, char_word, 4'd1);
                        end
                        klex_pkg::CH_OPEN: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_OPEN, char_word, 4'd1);
                        end
                        klex_pkg::CH_CLOSE: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_CLOSE, char_word, 4'd1);
                        end
                        default: begin
                            new_v   = 1'b1;
                            new_tok = klex_pkg::make_token(klex_pkg::K_ERR, char_word, 4'd1);
                        end
                    endcase
                end
            end

            if (is_eol) begin
                idx_next  = '0;
                line_next = line_reg + 16'd1;
            end else if (held_v && new_v) begin
                idx_next = idx_plus2;
            end else if (held_v || new_v) begin
                idx_next = idx_plus1;
            end
        end
    end

    // Order the beats: a flushed token goes ahead of the character's own.
    always_comb begin
        tok_a = held_v ? held_tok : new_tok;
        tok_b = new_tok;
        tok_a.line  = line_reg;
        tok_b.line  = line_reg;
        tok_a.index = idx_reg;
        tok_b.index = idx_plus1;
        tok_a.last  = !(held_v && new_v);
        tok_b.last  = 1'b1;
        push.count  = {1'b0, held_v} + {1'b0, new_v};
        push.slot_a = tok_a;
        push.slot_b = tok_b;
    end

    assign held_num_or_name = (mode_reg == klex_pkg::MODE_NUM)
                           || (mode_reg == klex_pkg::MODE_NAME);
    assign eol_in_idle      = in_valid && (mode_reg == klex_pkg::MODE_IDLE)
                           && (in_char == klex_pkg::CH_NUL);

    `KLEX_ALWAYS(a_name_not_empty, (mode_reg == klex_pkg::MODE_NAME) |-> (cnt_reg != 4'd0))
    `KLEX_ALWAYS(a_ovf_only_held, ovf_reg |-> held_num_or_name)
    `KLEX_NEXT(a_eol_resets_index, eol_in_idle, idx_reg == 8'd0)

endmodule

// ===== hdl/klex_queue.sv =====
// Result queue: takes up to two token beats a cycle, hands out one.
`include "assert_macros.svh"

module klex_queue (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  klex_pkg::push_t                              push,
    input  logic                                         pop,
    output logic                                         out_valid,
    output klex_pkg::token_t                             out_tok,
    output logic [$clog2(klex_pkg::QUEUE_DEPTH+1)-1:0]   count
);

    localparam int DEPTH = klex_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH+1);

    klex_pkg::token_t mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.slot_a;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + PW'(1)] <= push.slot_b;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem[rd_ptr_reg];
    assign count     = count_reg;

    `KLEX_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH))
    `KLEX_NEXT(a_push_two, (push.count == 2'd2) && !pop, count_reg == $past(count_reg) + CW'(2))
    `KLEX_ALWAYS(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == PW'(count_reg))

endmodule

// ===== hdl/keyword_operator_lexer.sv =====
// Lexer top level: one character per beat in, one token per beat out, up to
// two tokens per character. A character is taken every cycle while the
// eight-beat result queue has room for the two beats it may produce and the
// two still owed by the character in the input register; its tokens are written
// to the queue at the clock edge after the one that takes it. Numbers, names and
// the openers < > : are held until the next character decides them, so that
// character may emit the held token and its own one behind it. While m_tready is
// high, output drains one token per cycle; m_tlast marks a character's last token.
module keyword_operator_lexer #(
    parameter int MAX_NAME_CHARS = klex_pkg::MAX_NAME_CHARS_DEF,
    parameter int NUMBER_WIDTH   = klex_pkg::NUMBER_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_code
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // token_text, text_length, number_value,
                                    // source_line, token_index, truncated, zero pad
    output logic [4:0]   m_tuser,   // token_kind
    output logic         m_tlast
);

    localparam int CW = $clog2(klex_pkg::QUEUE_DEPTH+1);

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    klex_pkg::push_t  push;
    klex_pkg::token_t out_tok;
    logic [CW-1:0]    count;
    logic [CW:0]      committed;

    assign committed = {1'b0, count} + (in_valid_reg ? (CW+1)'(2) : (CW+1)'(0));
    assign s_tready  = (committed <= (CW+1)'(klex_pkg::QUEUE_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    klex_scan #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS),
        .NUMBER_WIDTH   (NUMBER_WIDTH)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_char  (in_char_reg),
        .push     (push)
    );

    klex_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tvalid && m_tready),
        .out_valid (m_tvalid),
        .out_tok   (out_tok),
        .count     (count)
    );

    assign m_tdata = {3'b000, out_tok.trunc, out_tok.index, out_tok.line,
                      out_tok.num, out_tok.len, out_tok.text};
    assign m_tuser = out_tok.kind;
    assign m_tlast = out_tok.last;

endmodule
